/* src/vffr_pkg.sv */
// Shared types, constants and helpers for the video frame fragment reassembler.
`timescale 1ns / 1ps

package vffr_pkg;

  localparam int MAX_FRAGS    = 64;
  localparam int TIME_W       = 48;
  localparam int SEQ_W        = 32;
  localparam int TOTAL_W      = 7;
  localparam int INDEX_W      = 6;
  localparam int INTERVAL_W   = 16;
  localparam int CNT_W        = 32;
  localparam int DROP_W       = 2;

  localparam logic [INTERVAL_W-1:0] IDR_INTERVAL_RESET = 16'd250;

  typedef enum logic [2:0] {
    ST_PENDING   = 3'd0,
    ST_STALE     = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_GAP       = 3'd3,
    ST_GAP_REQ   = 3'd4
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0]  time_ms;
    logic [SEQ_W-1:0]   seq_num;
    logic [TOTAL_W-1:0] frag_total;
    logic [INDEX_W-1:0] frag_pos;
    logic               is_keyframe;
  } frag_t;

  typedef struct packed {
    status_t            status;
    logic [SEQ_W-1:0]   done_seq;
    logic               done_keyframe;
    logic [SEQ_W-1:0]   request_last_good;
    logic [DROP_W-1:0]  dropped_now;
    logic [CNT_W-1:0]   stale_total;
    logic [CNT_W-1:0]   dropped_total;
    logic [CNT_W-1:0]   gap_total;
  } result_t;

  function automatic logic [TOTAL_W-1:0] popcount64(input logic [MAX_FRAGS-1:0] v);
    logic [TOTAL_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_FRAGS; i++) begin
      n = n + TOTAL_W'(v[i]);
    end
    return n;
  endfunction

endpackage

/* src/vffr_in_stage.sv */
// Input register stage: captures one fragment and hands it to the update logic.
`timescale 1ns / 1ps

module vffr_in_stage
  import vffr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  frag_t in_frag,
  input  logic  out_ready,
  output logic  step,
  output frag_t frag
);

  logic s1_valid;
  logic s1_valid_next;
  logic take;

  assign step     = s1_valid && out_ready;
  assign in_stall = s1_valid && !out_ready;
  assign take     = in_valid && !in_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (take) begin
      s1_valid_next = 1'b1;
    end else if (step) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frag <= in_frag;
    end
  end

endmodule

/* src/vffr_core.sv */
// Reassembly state: two frame slots, completion, drop, delivery and request logic.
`timescale 1ns / 1ps

module vffr_core
  import vffr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [INTERVAL_W-1:0] cfg_wr_data,
  input  logic                  step,
  input  frag_t                 frag,
  output result_t               res
);

  // state
  logic [1:0]           slot_valid;
  logic [SEQ_W-1:0]     slot_seq    [2];
  logic [TOTAL_W-1:0]   slot_need   [2];
  logic [1:0]           slot_key;
  logic [MAX_FRAGS-1:0] slot_bitmap [2];
  logic                 newest_valid;
  logic [SEQ_W-1:0]     newest_seq;
  logic                 decoded_valid;
  logic [SEQ_W-1:0]     decoded_seq;
  logic                 request_pending;
  logic                 request_time_valid;
  logic [TIME_W-1:0]    request_time;
  logic                 request_good_valid;
  logic [SEQ_W-1:0]     request_good_seq;
  logic [CNT_W-1:0]     stale_count;
  logic [CNT_W-1:0]     dropped_count;
  logic [CNT_W-1:0]     gap_count;
  logic [INTERVAL_W-1:0] idr_interval;

  logic [1:0]           slot_valid_next;
  logic [SEQ_W-1:0]     slot_seq_next    [2];
  logic [TOTAL_W-1:0]   slot_need_next   [2];
  logic [1:0]           slot_key_next;
  logic [MAX_FRAGS-1:0] slot_bitmap_next [2];
  logic                 newest_valid_next;
  logic [SEQ_W-1:0]     newest_seq_next;
  logic                 decoded_valid_next;
  logic [SEQ_W-1:0]     decoded_seq_next;
  logic                 request_pending_next;
  logic                 request_time_valid_next;
  logic [TIME_W-1:0]    request_time_next;
  logic                 request_good_valid_next;
  logic [SEQ_W-1:0]     request_good_seq_next;
  logic [CNT_W-1:0]     stale_count_next;
  logic [CNT_W-1:0]     dropped_count_next;
  logic [CNT_W-1:0]     gap_count_next;

  // working signals
  logic                 hit0, hit1, hit, full, old, newer_than_old;
  logic                 is_stale, evict, sel, other, complete, drop_other;
  logic                 deliver, too_soon, keyf;
  logic [1:0]           vld;
  logic [MAX_FRAGS-1:0] bm;
  logic [TOTAL_W-1:0]   need;
  logic [TOTAL_W-1:0]   pop;
  logic [DROP_W-1:0]    dropped;
  logic [TIME_W:0]      tdiff;
  logic [SEQ_W-1:0]     seq_m1;

  always_comb begin
    hit0 = slot_valid[0] && (slot_seq[0] == frag.seq_num);
    hit1 = slot_valid[1] && (slot_seq[1] == frag.seq_num);
    hit  = hit0 || hit1;
    full = slot_valid[0] && slot_valid[1];
    old  = slot_seq[1] < slot_seq[0];
    newer_than_old = frag.seq_num > slot_seq[old];

    is_stale = (newest_valid && (frag.seq_num <= newest_seq)) ||
               (!hit && full && !newer_than_old);
    evict    = !is_stale && !hit && full;

    vld = slot_valid;
    if (evict) begin
      vld[old] = 1'b0;
    end
    sel   = hit ? hit1 : vld[0];
    other = ~sel;

    bm   = (hit ? slot_bitmap[sel] : '0) | (MAX_FRAGS'(1) << frag.frag_pos);
    need = hit ? slot_need[sel] : frag.frag_total;
    keyf = hit ? slot_key[sel] : frag.is_keyframe;
    pop  = popcount64(bm);
    complete   = !is_stale && (pop == need);
    drop_other = complete && vld[other] && (slot_seq[other] <= frag.seq_num);
    dropped    = DROP_W'(evict) + DROP_W'(drop_other);

    seq_m1  = frag.seq_num - SEQ_W'(1);
    deliver = keyf ||
              (decoded_valid && (frag.seq_num != '0) && (decoded_seq == seq_m1));
    // signed time difference: backward time reads as too soon
    tdiff    = {1'b0, frag.time_ms} - {1'b0, request_time};
    too_soon = request_time_valid &&
               (tdiff[TIME_W] || (tdiff[TIME_W-1:0] < TIME_W'(idr_interval)));

    slot_valid_next         = slot_valid;
    slot_seq_next           = slot_seq;
    slot_need_next          = slot_need;
    slot_key_next           = slot_key;
    slot_bitmap_next        = slot_bitmap;
    newest_valid_next       = newest_valid;
    newest_seq_next         = newest_seq;
    decoded_valid_next      = decoded_valid;
    decoded_seq_next        = decoded_seq;
    request_pending_next    = request_pending;
    request_time_valid_next = request_time_valid;
    request_time_next       = request_time;
    request_good_valid_next = request_good_valid;
    request_good_seq_next   = request_good_seq;
    stale_count_next        = stale_count;
    dropped_count_next      = dropped_count;
    gap_count_next          = gap_count;

    res.status            = ST_PENDING;
    res.done_seq          = '0;
    res.done_keyframe     = 1'b0;
    res.request_last_good = '0;
    res.dropped_now       = dropped;

    if (is_stale) begin
      stale_count_next = stale_count + CNT_W'(1);
      res.status       = ST_STALE;
    end else begin
      slot_valid_next            = vld;
      slot_valid_next[sel]       = !complete;
      slot_seq_next[sel]         = frag.seq_num;
      slot_need_next[sel]        = need;
      slot_key_next[sel]         = keyf;
      slot_bitmap_next[sel]      = bm;
      if (drop_other) begin
        slot_valid_next[other] = 1'b0;
      end
      dropped_count_next = dropped_count + CNT_W'(dropped);

      if (complete) begin
        newest_valid_next = 1'b1;
        newest_seq_next   = frag.seq_num;
        res.done_seq      = frag.seq_num;
        res.done_keyframe = keyf;
        if (deliver) begin
          res.status         = ST_DELIVERED;
          decoded_valid_next = 1'b1;
          decoded_seq_next   = frag.seq_num;
          if (keyf && request_pending &&
              (!request_good_valid || (frag.seq_num > request_good_seq))) begin
            request_pending_next = 1'b0;
          end
        end else begin
          gap_count_next = gap_count + CNT_W'(1);
          res.status     = ST_GAP;
          if (!request_pending && !too_soon) begin
            res.status              = ST_GAP_REQ;
            res.request_last_good   = decoded_valid ? decoded_seq : '0;
            request_pending_next    = 1'b1;
            request_time_valid_next = 1'b1;
            request_time_next       = frag.time_ms;
            request_good_valid_next = decoded_valid;
            request_good_seq_next   = decoded_seq;
          end
        end
      end
    end

    res.stale_total   = stale_count_next;
    res.dropped_total = dropped_count_next;
    res.gap_total     = gap_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idr_interval <= IDR_INTERVAL_RESET;
    end else if (cfg_wr_en) begin
      idr_interval <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid         <= '0;
      newest_valid       <= 1'b0;
      decoded_valid      <= 1'b0;
      request_pending    <= 1'b0;
      request_time_valid <= 1'b0;
      request_good_valid <= 1'b0;
      stale_count        <= '0;
      dropped_count      <= '0;
      gap_count          <= '0;
    end else if (step) begin
      slot_valid         <= slot_valid_next;
      newest_valid       <= newest_valid_next;
      decoded_valid      <= decoded_valid_next;
      request_pending    <= request_pending_next;
      request_time_valid <= request_time_valid_next;
      request_good_valid <= request_good_valid_next;
      stale_count        <= stale_count_next;
      dropped_count      <= dropped_count_next;
      gap_count          <= gap_count_next;
    end
  end

  // payload state, only read behind a valid flag
  always_ff @(posedge clk) begin
    if (step) begin
      slot_seq         <= slot_seq_next;
      slot_need        <= slot_need_next;
      slot_key         <= slot_key_next;
      slot_bitmap      <= slot_bitmap_next;
      newest_seq       <= newest_seq_next;
      decoded_seq      <= decoded_seq_next;
      request_time     <= request_time_next;
      request_good_seq <= request_good_seq_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_slots_distinct: assert property (@(posedge clk) disable iff (rst)
    (slot_valid[0] && slot_valid[1]) |-> (slot_seq[0] != slot_seq[1]))
    else $error("two live slots hold the same frame");

  a_slots_above_newest: assert property (@(posedge clk) disable iff (rst)
    (newest_valid && (slot_valid[0] || slot_valid[1])) |->
    ((!slot_valid[0] || (slot_seq[0] > newest_seq)) &&
     (!slot_valid[1] || (slot_seq[1] > newest_seq))))
    else $error("live slot at or below newest completed frame");

  a_request_has_time: assert property (@(posedge clk) disable iff (rst)
    request_pending |-> request_time_valid)
    else $error("keyframe request pending without a request time");

  a_deliver_updates: assert property (@(posedge clk) disable iff (rst)
    (step && (res.status == ST_DELIVERED)) |=>
    (decoded_valid && (decoded_seq == $past(frag.seq_num))))
    else $error("delivered frame not recorded as last decoded");
`endif

endmodule

/* src/vffr_out_stage.sv */
// Result register: holds one result until the receiver takes it.
`timescale 1ns / 1ps

module vffr_out_stage
  import vffr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  result_t res,
  input  logic    out_stall,
  output logic    out_valid,
  output logic    out_ready,
  output result_t out_res
);

  logic out_valid_next;

  // room for a new result when empty or when the current one transfers now
  assign out_ready = !out_valid || !out_stall;

  always_comb begin
    out_valid_next = out_valid;
    if (step) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

endmodule

/* src/video_frame_fragment_reassembler.sv */
// Video frame fragment reassembler, top level.
// Usage:
//   Input channel in_valid/in_stall carries one fragment per transfer
//   (time_ms, seq_num, frag_total, frag_pos, is_keyframe).
//   Output channel out_valid/out_stall carries exactly one result per
//   fragment, in arrival order: status, completed frame, request data,
//   drop count of the step and the three running counters.
//   cfg_wr_en/cfg_wr_data write the minimum keyframe request interval in
//   ms; write it only while no fragment is in flight.
// Path: a fragment taken into the input register passes through the slot
//   update into the result register, from which its result transfers.
// Throughput: one fragment per cycle while the receiver does not stall;
//   the slot update is combinational, from input to result register.
// Reset (rst, synchronous): both slots empty, no frame completed or
//   decoded, no request pending, counters zero, interval back to 250 ms.
// Receiver stall: the result register holds; the input register then
//   fills and in_stall rises until the result is taken.
`timescale 1ns / 1ps

module video_frame_fragment_reassembler
  import vffr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [INTERVAL_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     time_ms,
  input  logic [SEQ_W-1:0]      seq_num,
  input  logic [TOTAL_W-1:0]    frag_total,
  input  logic [INDEX_W-1:0]    frag_pos,
  input  logic                  is_keyframe,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [SEQ_W-1:0]      done_seq,
  output logic                  done_keyframe,
  output logic [SEQ_W-1:0]      request_last_good,
  output logic [DROP_W-1:0]     dropped_now,
  output logic [CNT_W-1:0]      stale_total,
  output logic [CNT_W-1:0]      dropped_total,
  output logic [CNT_W-1:0]      gap_total
);

  frag_t   in_frag;
  frag_t   frag;
  result_t res;
  result_t out_res;
  logic    step;
  logic    out_ready;

  assign in_frag.time_ms     = time_ms;
  assign in_frag.seq_num     = seq_num;
  assign in_frag.frag_total  = frag_total;
  assign in_frag.frag_pos    = frag_pos;
  assign in_frag.is_keyframe = is_keyframe;

  vffr_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_frag   (in_frag),
    .out_ready (out_ready),
    .step      (step),
    .frag      (frag)
  );

  vffr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .frag        (frag),
    .res         (res)
  );

  vffr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign status            = out_res.status;
  assign done_seq          = out_res.done_seq;
  assign done_keyframe     = out_res.done_keyframe;
  assign request_last_good = out_res.request_last_good;
  assign dropped_now       = out_res.dropped_now;
  assign stale_total       = out_res.stale_total;
  assign dropped_total     = out_res.dropped_total;
  assign gap_total         = out_res.gap_total;

endmodule

/* tb/sv/tb_video_frame_fragment_reassembler.sv */
// Testbench: fragment table, then random frame streams, checked against a frame predictor.
`timescale 1ns / 1ps

module tb_video_frame_fragment_reassembler;
  import vffr_pkg::*;

  localparam int RAND_PER_PHASE = 263;
  localparam int N_DIRECTED     = 22;

  typedef struct packed {
    frag_t   f;
    logic    typed;
    result_t r;
  } dir_row_t;

  // typed rows: the first four steps after reset
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{48'd0, 32'd0, 7'd1, 6'd0, 1'b0}, 1'b1,
      '{ST_GAP_REQ, 32'd0, 1'b0, 32'd0, 2'd0, 32'd0, 32'd0, 32'd1}},
    '{'{48'hFFFF_FFFF_FFFF, 32'd0, 7'd1, 6'd0, 1'b0}, 1'b1,
      '{ST_STALE, 32'd0, 1'b0, 32'd0, 2'd0, 32'd1, 32'd0, 32'd1}},
    '{'{48'd10, 32'd5, 7'd1, 6'd0, 1'b1}, 1'b1,
      '{ST_DELIVERED, 32'd5, 1'b1, 32'd0, 2'd0, 32'd1, 32'd0, 32'd1}},
    '{'{48'd20, 32'd6, 7'd3, 6'd0, 1'b0}, 1'b1,
      '{ST_PENDING, 32'd0, 1'b0, 32'd0, 2'd0, 32'd1, 32'd0, 32'd1}},
    '{'{48'd21, 32'd6, 7'd3, 6'd0, 1'b0}, 1'b0, '0},  // duplicate
    '{'{48'd22, 32'd6, 7'd3, 6'd2, 1'b0}, 1'b0, '0},
    '{'{48'd23, 32'd6, 7'd3, 6'd1, 1'b0}, 1'b0, '0},  // follows decoded
    '{'{48'd30, 32'd10, 7'd2, 6'd0, 1'b0}, 1'b0, '0},
    '{'{48'd31, 32'd12, 7'd2, 6'd0, 1'b0}, 1'b0, '0},
    '{'{48'd32, 32'd11, 7'd2, 6'd0, 1'b0}, 1'b0, '0}, // full window, evicts 10
    '{'{48'd33, 32'd9, 7'd2, 6'd0, 1'b0}, 1'b0, '0},  // full window, stale
    '{'{48'd34, 32'd12, 7'd2, 6'd1, 1'b0}, 1'b0, '0}, // drops 11, gap inside interval
    '{'{48'd400, 32'd20, 7'd1, 6'd0, 1'b0}, 1'b0, '0},
    '{'{48'd401, 32'd22, 7'd1, 6'd0, 1'b0}, 1'b0, '0}, // request outstanding
    '{'{48'd500, 32'd25, 7'd1, 6'd0, 1'b1}, 1'b0, '0}, // clears request
    '{'{48'd300, 32'd27, 7'd1, 6'd0, 1'b0}, 1'b0, '0}, // time backward
    '{'{48'd600, 32'd30, 7'd0, 6'd0, 1'b0}, 1'b0, '0}, // zero count
    '{'{48'd601, 32'd31, 7'd64, 6'd63, 1'b1}, 1'b0, '0},
    '{'{48'd602, 32'd32, 7'd127, 6'd5, 1'b0}, 1'b0, '0}, // count above max
    '{'{48'd603, 32'd31, 7'd64, 6'd0, 1'b0}, 1'b0, '0},
    '{'{48'd700, 32'd40, 7'd1, 6'd0, 1'b1}, 1'b0, '0}, // drops both slots
    '{'{48'd800, 32'd42, 7'd1, 6'd0, 1'b0}, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [INTERVAL_W-1:0] cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TIME_W-1:0]     time_ms = '0;
  logic [SEQ_W-1:0]      seq_num = '0;
  logic [TOTAL_W-1:0]    frag_total = '0;
  logic [INDEX_W-1:0]    frag_pos = '0;
  logic                  is_keyframe = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            status;
  logic [SEQ_W-1:0]      done_seq;
  logic                  done_keyframe;
  logic [SEQ_W-1:0]      request_last_good;
  logic [DROP_W-1:0]     dropped_now;
  logic [CNT_W-1:0]      stale_total;
  logic [CNT_W-1:0]      dropped_total;
  logic [CNT_W-1:0]      gap_total;

  video_frame_fragment_reassembler u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .time_ms           (time_ms),
    .seq_num           (seq_num),
    .frag_total        (frag_total),
    .frag_pos          (frag_pos),
    .is_keyframe       (is_keyframe),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .done_seq          (done_seq),
    .done_keyframe     (done_keyframe),
    .request_last_good (request_last_good),
    .dropped_now       (dropped_now),
    .stale_total       (stale_total),
    .dropped_total     (dropped_total),
    .gap_total         (gap_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the reassembly state
  logic                  slot_on [2];
  logic [SEQ_W-1:0]      slot_sq [2];
  logic [TOTAL_W-1:0]    slot_len [2];
  logic                  slot_kf [2];
  logic [MAX_FRAGS-1:0]  slot_bits [2];
  longint                last_done = -1;
  logic                  have_decoded = 1'b0;
  logic [SEQ_W-1:0]      decoded_sq = '0;
  logic                  req_open = 1'b0;
  logic                  req_t_set = 1'b0;
  logic [TIME_W-1:0]     req_t = '0;
  logic                  req_good_set = 1'b0;
  logic [SEQ_W-1:0]      req_good_sq = '0;
  logic [CNT_W-1:0]      n_stale = '0;
  logic [CNT_W-1:0]      n_dropped = '0;
  logic [CNT_W-1:0]      n_gap = '0;
  logic [INTERVAL_W-1:0] min_gap_ms = IDR_INTERVAL_RESET;

  result_t outcome_q [$];
  int      mismatches = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  bit      quiet = 1'b0;

  // random stream generator: two frames in flight
  logic              g_act [2];
  logic [SEQ_W-1:0]  g_seq [2];
  logic [TOTAL_W-1:0] g_total [2];
  logic              g_key [2];
  int                g_left [2][$];
  logic [SEQ_W-1:0]  gen_seq = 32'd50;
  logic [TIME_W-1:0] gen_time = 48'd2000;

  initial begin
    for (int i = 0; i < 2; i++) begin
      slot_on[i] = 1'b0;
      slot_sq[i] = '0;
      slot_len[i] = '0;
      slot_kf[i] = 1'b0;
      slot_bits[i] = '0;
      g_act[i] = 1'b0;
      g_seq[i] = '0;
      g_total[i] = '0;
      g_key[i] = 1'b0;
    end
  end

  function automatic result_t reassemble(input frag_t f);
    result_t r;
    int      s;
    int      old;
    logic    kf;
    logic    rejected;
    r = '0;
    r.status = ST_PENDING;
    s = -1;
    rejected = 1'b0;
    if (longint'(f.seq_num) <= last_done) begin
      n_stale = n_stale + 1;
      r.status = ST_STALE;
      rejected = 1'b1;
    end else begin
      for (int i = 0; i < 2; i++)
        if (slot_on[i] && slot_sq[i] == f.seq_num) s = i;
      if (s < 0 && slot_on[0] && slot_on[1]) begin
        old = (slot_sq[1] < slot_sq[0]) ? 1 : 0;
        if (f.seq_num > slot_sq[old]) begin
          slot_on[old] = 1'b0;
          n_dropped = n_dropped + 1;
          r.dropped_now = r.dropped_now + 2'd1;
        end else begin
          n_stale = n_stale + 1;
          r.status = ST_STALE;
          rejected = 1'b1;
        end
      end
    end
    if (!rejected) begin
      if (s < 0) begin
        s = slot_on[0] ? 1 : 0;
        slot_on[s] = 1'b1;
        slot_sq[s] = f.seq_num;
        slot_len[s] = f.frag_total;
        slot_kf[s] = f.is_keyframe;
        slot_bits[s] = '0;
      end
      slot_bits[s][f.frag_pos] = 1'b1;
      if ($countones(slot_bits[s]) == slot_len[s]) begin
        kf = slot_kf[s];
        slot_on[s] = 1'b0;
        slot_bits[s] = '0;
        if (longint'(f.seq_num) > last_done) last_done = longint'(f.seq_num);
        for (int i = 0; i < 2; i++) begin
          if (slot_on[i] && longint'(slot_sq[i]) <= last_done) begin
            slot_on[i] = 1'b0;
            slot_bits[i] = '0;
            n_dropped = n_dropped + 1;
            r.dropped_now = r.dropped_now + 2'd1;
          end
        end
        r.done_seq = f.seq_num;
        r.done_keyframe = kf;
        if (kf || (have_decoded && f.seq_num != 0 && decoded_sq == f.seq_num - 32'd1)) begin
          r.status = ST_DELIVERED;
          have_decoded = 1'b1;
          decoded_sq = f.seq_num;
          if (kf && req_open && (!req_good_set || f.seq_num > req_good_sq))
            req_open = 1'b0;
        end else begin
          n_gap = n_gap + 1;
          r.status = ST_GAP;
          // elapsed time is signed, so a clock going backward never requests
          if (!req_open && !(req_t_set &&
              (longint'(f.time_ms) - longint'(req_t) < longint'(min_gap_ms)))) begin
            r.status = ST_GAP_REQ;
            r.request_last_good = have_decoded ? decoded_sq : '0;
            req_open = 1'b1;
            req_t_set = 1'b1;
            req_t = f.time_ms;
            req_good_set = have_decoded;
            req_good_sq = decoded_sq;
          end
        end
      end
    end
    r.stale_total = n_stale;
    r.dropped_total = n_dropped;
    r.gap_total = n_gap;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (outcome_q.size() == 0) begin
        $error("result transfer with no fragment outstanding");
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        compare_field("status", 64'(want.status), 64'(status));
        compare_field("done_seq", 64'(want.done_seq), 64'(done_seq));
        compare_field("done_keyframe", 64'(want.done_keyframe), 64'(done_keyframe));
        compare_field("request_last_good", 64'(want.request_last_good),
                      64'(request_last_good));
        compare_field("dropped_now", 64'(want.dropped_now), 64'(dropped_now));
        compare_field("stale_total", 64'(want.stale_total), 64'(stale_total));
        compare_field("dropped_total", 64'(want.dropped_total), 64'(dropped_total));
        compare_field("gap_total", 64'(want.gap_total), 64'(gap_total));
      end
    end
  end

  always @(posedge clk)
    out_stall <= !quiet && ($urandom_range(0, 99) < stall_pct);

  // called at a clock edge; returns at the edge that takes the transfer
  task automatic send_fragment(input frag_t f, input logic typed, input result_t typed_r);
    result_t p;
    int      gap;
    gap = 0;
    if (!quiet)
      while (gap < 200 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    time_ms <= f.time_ms;
    seq_num <= f.seq_num;
    frag_total <= f.frag_total;
    frag_pos <= f.frag_pos;
    is_keyframe <= f.is_keyframe;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    p = reassemble(f);
    outcome_q.insert(outcome_q.size(), typed ? typed_r : p);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_interval(input logic [INTERVAL_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    min_gap_ms = v;
  endtask

  task automatic next_random_fragment(output frag_t f);
    int r;
    int k;
    int g;
    int n;
    k = $urandom_range(0, 99);
    if (k < 5) gen_time = gen_time - TIME_W'($urandom_range(0, 400));
    else if (k < 10) gen_time = gen_time + TIME_W'($urandom_range(200, 70000));
    else gen_time = gen_time + TIME_W'($urandom_range(0, 60));
    f.time_ms = gen_time;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // noise: arbitrary fields near the live sequence range
      f.seq_num = gen_seq - SEQ_W'($urandom_range(0, 12));
      f.frag_total = TOTAL_W'($urandom_range(0, 127));
      f.frag_pos = INDEX_W'($urandom_range(0, 63));
      f.is_keyframe = 1'($urandom_range(0, 1));
    end else begin
      g = $urandom_range(0, 1);
      if (!g_act[g]) begin
        gen_seq = gen_seq +
                  SEQ_W'(($urandom_range(0, 99) < 85) ? 1 : $urandom_range(2, 4));
        g_seq[g] = gen_seq;
        k = $urandom_range(0, 99);
        if (k < 70) n = $urandom_range(1, 4);
        else if (k < 95) n = $urandom_range(5, 16);
        else n = $urandom_range(17, 64);
        g_total[g] = TOTAL_W'(n);
        g_key[g] = $urandom_range(0, 99) < 12;
        g_left[g].delete();
        for (int i = 0; i < n; i++)
          g_left[g].insert($urandom_range(0, g_left[g].size()), i);
        if (n > 1 && $urandom_range(0, 99) < 6) void'(g_left[g].pop_back());
        if ($urandom_range(0, 99) < 5)
          g_left[g].insert($urandom_range(0, g_left[g].size()), $urandom_range(0, n - 1));
        g_act[g] = 1'b1;
      end
      f.seq_num = g_seq[g];
      f.frag_total = g_total[g];
      f.is_keyframe = g_key[g];
      f.frag_pos = INDEX_W'(g_left[g].pop_front());
      if (g_left[g].size() == 0) g_act[g] = 1'b0;
    end
  endtask

  initial begin
    frag_t f;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_interval(IDR_INTERVAL_RESET);
    for (int i = 0; i < N_DIRECTED; i++)
      send_fragment(DIRECTED[i].f, DIRECTED[i].typed, DIRECTED[i].r);
    for (int ph = 1; ph <= 4; ph++) begin
      drain();
      case (ph)
        1: begin
          write_interval('0);
          idle_pct = 0;
          stall_pct = 0;
        end
        2: begin
          write_interval('1);
          idle_pct = 76;
          stall_pct = 0;
        end
        3: begin
          write_interval(INTERVAL_W'($urandom_range(1, 65534)));
          idle_pct = 0;
          stall_pct = 76;
        end
        default: begin
          write_interval(16'd1);
          idle_pct = 29;
          stall_pct = 29;
          // move to the top of the sequence space
          gen_seq = 32'hFFFF_F000;
        end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        quiet = (n % 40) >= 32;
        next_random_fragment(f);
        send_fragment(f, 1'b0, '0);
      end
    end
    quiet = 1'b0;
    // largest sequence completes, then is stale
    f = '{gen_time, 32'hFFFF_FFFF, 7'd1, 6'd0, 1'b1};
    send_fragment(f, 1'b0, '0);
    send_fragment(f, 1'b0, '0);
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("video_frame_fragment_reassembler: match");
    else
      $display("video_frame_fragment_reassembler: mismatch");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("video_frame_fragment_reassembler: mismatch");
    $finish;
  end

endmodule

/* video_frame_fragment_reassembler.f */
src/vffr_pkg.sv
src/vffr_in_stage.sv
src/vffr_core.sv
src/vffr_out_stage.sv
src/video_frame_fragment_reassembler.sv
tb/sv/tb_video_frame_fragment_reassembler.sv
